[design/kma_pkg.sv]
// shared types, constants and helpers of the k-medoids assignment block
package kma_pkg;

  localparam int DIST_W    = 20;
  localparam int COST_W    = 32;
  localparam int CIDX_W    = 4;
  localparam int FIELD_W   = 4;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = 7;
  localparam int OUT_W     = CIDX_W + DIST_W + COST_W;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEDOID_COUNT    = 2'd0,
    CFG_DIMENSION_COUNT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic step;
    logic finish;
  } dist_ctrl_t;

  // limit a count register to 1..max
  function automatic logic [CNT_W-1:0] clamp_count(logic [CFG_W-1:0] v, int unsigned max);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (32'(v) > max) begin
      r = CNT_W'(max);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

[design/kma_ram.sv]
// generic single-write, single-read ram with registered read
module kma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/kma_dist.sv]
// running manhattan distances per medoid and the captured totals of a finished point
module kma_dist #(
  parameter int MAX_MEDOIDS = 16,
  parameter int COORD_WIDTH = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  kma_pkg::dist_ctrl_t                         ctrl,
  input  logic [MAX_MEDOIDS-1:0]                      act,
  input  logic signed [COORD_WIDTH-1:0]               coord,
  input  logic [MAX_MEDOIDS-1:0][COORD_WIDTH-1:0]     med,
  output logic [MAX_MEDOIDS-1:0][kma_pkg::DIST_W-1:0] final_dist
);

  localparam int ABS_W = COORD_WIDTH + 1;
  localparam int SUM_W = ((ABS_W > kma_pkg::DIST_W) ? ABS_W : kma_pkg::DIST_W) + 1;

  logic [MAX_MEDOIDS-1:0][kma_pkg::DIST_W-1:0] part_r, part_nxt, sat_d;

  for (genvar k = 0; k < MAX_MEDOIDS; k++) begin : g_med
    logic signed [ABS_W-1:0] diff;
    logic [ABS_W-1:0]        mag;
    logic [SUM_W-1:0]        sum;

    always_comb begin
      diff = ABS_W'(coord) - ABS_W'($signed(med[k]));
      mag  = diff[ABS_W-1] ? ABS_W'(-diff) : ABS_W'(diff);
      sum  = SUM_W'(part_r[k]) + SUM_W'(mag);
      sat_d[k] = (sum > SUM_W'(kma_pkg::DIST_MAX)) ? kma_pkg::DIST_MAX
                                                    : sum[kma_pkg::DIST_W-1:0];
      part_nxt[k] = part_r[k];
      if (ctrl.step) begin
        if (ctrl.finish) begin
          part_nxt[k] = '0;
        end else if (act[k]) begin
          part_nxt[k] = sat_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= '0;
    end else begin
      part_r <= part_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      final_dist <= sat_d;
    end
  end

endmodule

[design/kma_argmin.sv]
// nearest-medoid search over the finished distances, lowest index on a tie
module kma_argmin #(
  parameter int MAX_MEDOIDS = 16,
  localparam int IDX_W = (MAX_MEDOIDS > 1) ? $clog2(MAX_MEDOIDS) : 1
) (
  input  logic                                        clk,
  input  logic                                        load,
  input  logic [MAX_MEDOIDS-1:0]                      act,
  input  logic [MAX_MEDOIDS-1:0][kma_pkg::DIST_W-1:0] cand_dist,
  output logic [IDX_W-1:0]                            best_idx,
  output logic [kma_pkg::DIST_W-1:0]                  best_dist
);

  localparam int LEAVES = 1 << IDX_W;

  logic                       node_v [1:2*LEAVES-1];
  logic [kma_pkg::DIST_W-1:0] node_d [1:2*LEAVES-1];
  logic [IDX_W-1:0]           node_i [1:2*LEAVES-1];

  for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
    if (j < MAX_MEDOIDS) begin : g_used
      assign node_v[LEAVES+j] = act[j];
      assign node_d[LEAVES+j] = cand_dist[j];
    end else begin : g_pad
      assign node_v[LEAVES+j] = 1'b0;
      assign node_d[LEAVES+j] = '0;
    end
    assign node_i[LEAVES+j] = IDX_W'(j);
  end

  // left child always holds the lower indexes
  for (genvar i = 1; i < LEAVES; i++) begin : g_node
    logic take_b;
    assign take_b = node_v[2*i+1] && (!node_v[2*i] || (node_d[2*i+1] < node_d[2*i]));
    assign node_v[i] = node_v[2*i] | node_v[2*i+1];
    assign node_d[i] = take_b ? node_d[2*i+1] : node_d[2*i];
    assign node_i[i] = take_b ? node_i[2*i+1] : node_i[2*i];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      best_idx  <= node_i[1];
      best_dist <= node_d[1];
    end
  end

endmodule

[design/kmedoids_manhattan_assign.sv]
// top level of the k-medoids assignment block with manhattan distance
//
//  channel | direction | handshake          | payload
//  in_     | slave     | in_tvalid/in_tready  | tdata medoid/dim index, coordinate; tuser mode;
//          |           |                      | tlast last point
//  out_    | master    | out_tvalid/out_tready| tdata cluster, distance, cost; tlast cost final
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index register, cfg_data value
//
// one request per cycle is taken while the pipeline does not stall; the medoid rams are banked one per medoid so every
// medoid coordinate at the current position is read in the same cycle
// a result passes through the final distance, nearest-medoid and output registers after
// the stage-one register takes the last coordinate of a point
// each stage holds its item only when the stage after it is full, so bubbles close up
// reset (synchronous, rst_n low) clears distances, counter and cost; medoid rams are
// not cleared and need no clearing pass
module kmedoids_manhattan_assign #(
  parameter int MAX_MEDOIDS    = 16,
  parameter int MAX_DIMENSIONS = 16,
  parameter int COORD_WIDTH    = 16,
  localparam int IN_W = ((2 * kma_pkg::FIELD_W + COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_W-1:0]                   in_tdata,   // medoid_index, dimension_index, coordinate
  input  logic                              in_tuser,   // mode
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [kma_pkg::OUT_W-1:0]         out_tdata,  // cluster_index, point_distance, total_cost
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kma_pkg::CFG_W-1:0]         cfg_data
);

  localparam int DIM_W = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
  localparam int IDX_W = (MAX_MEDOIDS > 1) ? $clog2(MAX_MEDOIDS) : 1;
  localparam int CW    = kma_pkg::CNT_W;

  // input fields
  logic [kma_pkg::FIELD_W-1:0] in_mi, in_di;
  logic [COORD_WIDTH-1:0]      in_coord;
  logic [31:0]                 di_ext;
  logic                        accept;

  assign in_mi    = in_tdata[kma_pkg::FIELD_W-1:0];
  assign in_di    = in_tdata[2*kma_pkg::FIELD_W-1:kma_pkg::FIELD_W];
  assign in_coord = in_tdata[2*kma_pkg::FIELD_W +: COORD_WIDTH];
  assign di_ext   = 32'(in_di);
  assign accept   = in_tvalid && in_tready;

  // configuration
  logic [kma_pkg::CFG_W-1:0] medoid_count_r, dimension_count_r;
  logic [CW-1:0]             nm_eff, nd_eff;
  logic [MAX_MEDOIDS-1:0]    act_r;

  assign cfg_ready = 1'b1;
  assign nm_eff = kma_pkg::clamp_count(medoid_count_r, MAX_MEDOIDS);
  assign nd_eff = kma_pkg::clamp_count(dimension_count_r, MAX_DIMENSIONS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      medoid_count_r    <= kma_pkg::CFG_W'(1);
      dimension_count_r <= kma_pkg::CFG_W'(1);
      act_r             <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          kma_pkg::CFG_MEDOID_COUNT:    medoid_count_r    <= cfg_data;
          kma_pkg::CFG_DIMENSION_COUNT: dimension_count_r <= cfg_data;
          default: ;
        endcase
      end
      for (int k = 0; k < MAX_MEDOIDS; k++) begin
        act_r[k] <= (CW'(k) < nm_eff);
      end
    end
  end

  // coordinate counter and point end detection
  logic [DIM_W-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]    cnt_plus;
  logic             pt_end;

  assign cnt_plus = CW'(cnt_r) + CW'(1);
  assign pt_end   = (cnt_plus >= nd_eff);

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && in_tuser) begin
      cnt_nxt = pt_end ? '0 : cnt_plus[DIM_W-1:0];
    end
  end

  // medoid banks
  logic [MAX_MEDOIDS-1:0][COORD_WIDTH-1:0] med_rd;
  logic                                    load_ok;

  assign load_ok = accept && !in_tuser && (32'(in_mi) < MAX_MEDOIDS)
                   && (di_ext < MAX_DIMENSIONS);

  for (genvar k = 0; k < MAX_MEDOIDS; k++) begin : g_bank
    kma_ram #(
      .WIDTH (COORD_WIDTH),
      .DEPTH (MAX_DIMENSIONS)
    ) u_ram (
      .clk   (clk),
      .we    (load_ok && (32'(in_mi) == k)),
      .waddr (di_ext[DIM_W-1:0]),
      .wdata (in_coord),
      .re    (accept),
      .raddr (cnt_r),
      .rdata (med_rd[k])
    );
  end

  // pipeline control
  logic v1_r, v2_r, v3_r, v4_r;
  logic s1_pt_r, s1_end_r, s1_last_r, s2_last_r, s3_last_r;
  logic signed [COORD_WIDTH-1:0] s1_coord_r;
  logic r2, r3, r4, m1;
  kma_pkg::dist_ctrl_t dctrl;
  logic load3, load4;

  assign r4 = !v4_r || out_tready;
  assign r3 = !v3_r || r4;
  assign r2 = !v2_r || r3;
  assign m1 = v1_r && (!(s1_pt_r && s1_end_r) || r2);
  assign in_tready = !v1_r || m1;

  assign dctrl.step   = m1 && s1_pt_r;
  assign dctrl.finish = m1 && s1_pt_r && s1_end_r;
  assign load3 = v2_r && r3;
  assign load4 = v3_r && r4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      v1_r  <= accept | (v1_r & !m1);
      v2_r  <= dctrl.finish | (v2_r & !r3);
      v3_r  <= load3 | (v3_r & !r4);
      v4_r  <= load4 | (v4_r & !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pt_r    <= in_tuser;
      s1_end_r   <= pt_end;
      s1_last_r  <= in_tlast;
      s1_coord_r <= $signed(in_coord);
    end
    if (dctrl.finish) begin
      s2_last_r <= s1_last_r;
    end
    if (load3) begin
      s3_last_r <= s2_last_r;
    end
  end

  // distances and nearest medoid
  logic [MAX_MEDOIDS-1:0][kma_pkg::DIST_W-1:0] final_dist;
  logic [IDX_W-1:0]                            best_idx;
  logic [kma_pkg::DIST_W-1:0]                  best_dist;

  kma_dist #(
    .MAX_MEDOIDS (MAX_MEDOIDS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (dctrl),
    .act        (act_r),
    .coord      (s1_coord_r),
    .med        (med_rd),
    .final_dist (final_dist)
  );

  kma_argmin #(
    .MAX_MEDOIDS (MAX_MEDOIDS)
  ) u_argmin (
    .clk       (clk),
    .load      (load3),
    .act       (act_r),
    .cand_dist (final_dist),
    .best_idx  (best_idx),
    .best_dist (best_dist)
  );

  // clustering cost and output register
  logic [kma_pkg::COST_W-1:0]   cost_r, cost_sat;
  logic [kma_pkg::COST_W:0]     cost_sum;
  logic [31:0]                  idx_ext;
  logic [kma_pkg::CIDX_W-1:0]   o_idx_r;
  logic [kma_pkg::DIST_W-1:0]   o_dist_r;
  logic [kma_pkg::COST_W-1:0]   o_cost_r;
  logic                         o_last_r;

  assign cost_sum = (kma_pkg::COST_W+1)'(cost_r) + (kma_pkg::COST_W+1)'(best_dist);
  assign cost_sat = cost_sum[kma_pkg::COST_W] ? kma_pkg::COST_MAX
                                              : cost_sum[kma_pkg::COST_W-1:0];
  assign idx_ext  = 32'(best_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r <= '0;
    end else if (load4) begin
      cost_r <= s3_last_r ? '0 : cost_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (load4) begin
      o_idx_r  <= idx_ext[kma_pkg::CIDX_W-1:0];
      o_dist_r <= best_dist;
      o_cost_r <= cost_sat;
      o_last_r <= s3_last_r;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {o_cost_r, o_dist_r, o_idx_r};
  assign out_tlast  = o_last_r;

endmodule

[design/kma_checker.sv]
// port-level checks on the assignment block, bound to the top level
module kma_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [kma_pkg::OUT_W-1:0]     out_tdata,
  input logic                          out_tlast
);

  localparam int DLO = kma_pkg::CIDX_W;
  localparam int CLO = kma_pkg::CIDX_W + kma_pkg::DIST_W;

  logic [kma_pkg::DIST_W-1:0] pt_dist;
  logic [kma_pkg::COST_W-1:0] cost;
  logic                       prev_v_r, prev_final_r;
  logic [kma_pkg::COST_W-1:0] prev_cost_r;

  assign pt_dist = out_tdata[CLO-1:DLO];
  assign cost    = out_tdata[kma_pkg::OUT_W-1:CLO];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_v_r     <= 1'b0;
      prev_final_r <= 1'b0;
      prev_cost_r  <= '0;
    end else if (out_tvalid && out_tready) begin
      prev_v_r     <= 1'b1;
      prev_final_r <= out_tlast;
      prev_cost_r  <= cost;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_cost_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (cost >= kma_pkg::COST_W'(pt_dist)))
    else $error("cost below the point distance");

  a_cost_grows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && prev_v_r && !prev_final_r |-> (cost >= prev_cost_r))
    else $error("cost fell inside a dataset");

  a_cost_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && prev_v_r && prev_final_r |-> (cost == kma_pkg::COST_W'(pt_dist)))
    else $error("cost not restarted after the final point");

endmodule

bind kmedoids_manhattan_assign kma_checker u_kma_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
